### src/ple_pkg.sv
package ple_pkg;

  localparam int unsigned POS_W   = 5;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned LEN_W   = 5;
  // Wide enough to address every cell of the deepest supported chain.
  localparam int unsigned PIVOT_W = 6;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_DELETE  = 2'd1,
    OP_REVERSE = 2'd2,
    OP_DUMP    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_ROTATE = 2'd3
  } cell_cmd_e;

  typedef struct packed {
    cell_cmd_e          cmd;
    logic [PIVOT_W-1:0] pivot;
  } cell_ctrl_t;

endpackage

### src/ple_cell.sv
module ple_cell import ple_pkg::*; #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned INDEX      = 0
) (
  input  logic                  clk_i,
  input  cell_ctrl_t            ctrl_i,
  input  logic [DATA_WIDTH-1:0] bcast_i,
  input  logic [DATA_WIDTH-1:0] left_i,
  input  logic [DATA_WIDTH-1:0] right_i,
  output logic [DATA_WIDTH-1:0] data_o
);

  localparam logic [PIVOT_W-1:0] Idx = PIVOT_W'(INDEX);

  logic [DATA_WIDTH-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    unique case (ctrl_i.cmd)
      CMD_HOLD: begin
        data_d = data_q;
      end
      CMD_INSERT: begin
        priority if (Idx > ctrl_i.pivot) begin
          data_d = left_i;
        end else if (Idx == ctrl_i.pivot) begin
          data_d = bcast_i;
        end else begin
          data_d = data_q;
        end
      end
      CMD_DELETE: begin
        if (Idx >= ctrl_i.pivot) begin
          data_d = right_i;
        end
      end
      CMD_ROTATE: begin
        priority if (Idx < ctrl_i.pivot) begin
          data_d = right_i;
        end else if (Idx == ctrl_i.pivot) begin
          data_d = bcast_i;
        end else begin
          data_d = data_q;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

### src/positional_list_engine.sv
// Ordered list of up to DEPTH words held in a chain of cells, head in the first cell. Each
// request is accepted in the idle state and then carried out in the execute state, where
// insert and delete finish. Reverse of two or more elements then goes on in the reverse
// state: one rotation for each element but one, and a last step that issues the result.
// Dump then emits one element per cycle while the output is taken. Each rotation turns a
// prefix of the cell chain by one place, with the head cell broadcast back into the chain.
// The execute state, each dump step and the last reverse step wait while the output
// register holds a result that is not being taken. The output holds one result in a
// register, so a new request is accepted while a result still waits to be taken.
module positional_list_engine import ple_pkg::*; #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              op_i,
  input  logic [POS_W-1:0]        position_i,
  input  logic signed [VAL_W-1:0] value_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [1:0]              status_o,
  output logic signed [VAL_W-1:0] element_o,
  output logic [LEN_W-1:0]        length_o,
  output logic                    last_o
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_REV  = 4'b0100,
    S_DUMP = 4'b1000
  } state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [IDX_W-1:0]   rev_q, rev_d;
  logic [IDX_W-1:0]   dump_q, dump_d;
  op_e                op_q;
  logic [POS_W-1:0]   pos_q;
  logic [VAL_W-1:0]   val_q;

  logic               out_valid_q;
  status_e            status_q;
  logic [VAL_W-1:0]   elem_q;
  logic [LEN_W-1:0]   len_q;
  logic               last_q;

  cell_ctrl_t            ctrl;
  logic [DATA_WIDTH-1:0] bcast;
  logic [DATA_WIDTH-1:0] cell_data [DEPTH];

  logic               accept;
  logic               can_push;
  logic               push;
  status_e            push_status;
  logic [VAL_W-1:0]   push_elem;
  logic               push_last;
  logic [LEN_W-1:0]   push_len;
  logic [7:0]         cnt_wide;
  logic [63:0]        head_wide;
  logic [63:0]        val_wide;

  logic [CMP_W-1:0]   pos_ext, cnt_ext;
  logic               is_full, is_empty, ins_bad, del_bad;
  logic [PIVOT_W-1:0] pivot_pos;
  logic [IDX_W-1:0]   n_m1;

  assign accept   = in_valid_i && in_ready_o;
  assign can_push = !out_valid_q || out_ready_i;

  assign pos_ext   = CMP_W'(pos_q);
  assign cnt_ext   = CMP_W'(count_q);
  assign is_full   = (count_q == CNT_W'(DEPTH));
  assign is_empty  = (count_q == '0);
  assign ins_bad   = (pos_q == '0) || (pos_ext > cnt_ext + CMP_W'(1));
  assign del_bad   = (pos_q == '0) || (pos_ext > cnt_ext);
  assign pivot_pos = PIVOT_W'(pos_q - POS_W'(1));
  assign n_m1      = IDX_W'(count_q - CNT_W'(1));

  assign head_wide = 64'(cell_data[0]);
  assign val_wide  = 64'(val_q);
  assign bcast     = (ctrl.cmd == CMD_INSERT) ? val_wide[DATA_WIDTH-1:0] : cell_data[0];

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    rev_d       = rev_q;
    dump_d      = dump_q;
    ctrl.cmd    = CMD_HOLD;
    ctrl.pivot  = '0;
    push        = 1'b0;
    push_status = ST_OK;
    push_elem   = '0;
    push_last   = 1'b1;
    in_ready_o  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (can_push) begin
          unique case (op_q)
            OP_INSERT: begin
              push    = 1'b1;
              state_d = S_IDLE;
              priority if (is_full) begin
                push_status = ST_FULL;
              end else if (ins_bad) begin
                push_status = ST_RANGE;
              end else begin
                ctrl.cmd   = CMD_INSERT;
                ctrl.pivot = pivot_pos;
                count_d    = count_q + CNT_W'(1);
              end
            end
            OP_DELETE: begin
              push    = 1'b1;
              state_d = S_IDLE;
              priority if (is_empty) begin
                push_status = ST_EMPTY;
              end else if (del_bad) begin
                push_status = ST_RANGE;
              end else begin
                ctrl.cmd   = CMD_DELETE;
                ctrl.pivot = pivot_pos;
                count_d    = count_q - CNT_W'(1);
              end
            end
            OP_REVERSE: begin
              if (count_q < CNT_W'(2)) begin
                push    = 1'b1;
                state_d = S_IDLE;
              end else begin
                rev_d   = n_m1;
                state_d = S_REV;
              end
            end
            OP_DUMP: begin
              if (is_empty) begin
                push        = 1'b1;
                push_status = ST_EMPTY;
                state_d     = S_IDLE;
              end else begin
                dump_d  = '0;
                state_d = S_DUMP;
              end
            end
          endcase
        end
      end
      S_REV: begin
        if (rev_q != '0) begin
          ctrl.cmd   = CMD_ROTATE;
          ctrl.pivot = PIVOT_W'(rev_q);
          rev_d      = rev_q - IDX_W'(1);
        end else if (can_push) begin
          push    = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_DUMP: begin
        if (can_push) begin
          push       = 1'b1;
          push_elem  = head_wide[VAL_W-1:0];
          push_last  = (dump_q == n_m1);
          ctrl.cmd   = CMD_ROTATE;
          ctrl.pivot = PIVOT_W'(n_m1);
          dump_d     = dump_q + IDX_W'(1);
          if (push_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign cnt_wide = 8'(count_d);
  assign push_len = cnt_wide[LEN_W-1:0];

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] left, right;
    if (g == 0) begin : g_first
      assign left = cell_data[g];
    end else begin : g_mid
      assign left = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right = cell_data[g];
    end else begin : g_inner
      assign right = cell_data[g+1];
    end
    ple_cell #(
      .DATA_WIDTH(DATA_WIDTH),
      .INDEX     (g)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .bcast_i(bcast),
      .left_i (left),
      .right_i(right),
      .data_o (cell_data[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rev_q       <= '0;
      dump_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      rev_q   <= rev_d;
      dump_q  <= dump_d;
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= op_e'(op_i);
      pos_q <= position_i;
      val_q <= value_i;
    end
    if (push) begin
      status_q <= push_status;
      elem_q   <= push_elem;
      len_q    <= push_len;
      last_q   <= push_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign element_o   = signed'(elem_q);
  assign length_o    = len_q;
  assign last_o      = last_q;

endmodule

### verif/tb_positional_list_engine.sv
`timescale 1ns / 100ps

module tb_positional_list_engine import ple_pkg::*;;

  localparam int unsigned LIST_DEPTH = 16;
  localparam int unsigned PHASE_ITEMS = 51;
  localparam int unsigned LONG_HOLD = 300;

  typedef struct {
    status_e                 status;
    logic signed [VAL_W-1:0] element;
    logic [LEN_W-1:0]        length;
    logic                    last;
  } list_result_t;

  class list_shadow;
    logic signed [VAL_W-1:0] cells [LIST_DEPTH];
    int unsigned             held;
    list_result_t            pending_results [$];
    int unsigned             faults;

    function int unsigned held_count();
      return held;
    endfunction

    function int unsigned waiting();
      return pending_results.size();
    endfunction

    function void push_result(status_e st, logic signed [VAL_W-1:0] elem, logic fin);
      list_result_t r;
      r.status  = st;
      r.element = elem;
      r.length  = held[LEN_W-1:0];
      r.last    = fin;
      pending_results.push_back(r);
    endfunction

    function void apply_request(op_e op, logic [POS_W-1:0] pos,
                                logic signed [VAL_W-1:0] val);
      status_e                 st;
      logic signed [VAL_W-1:0] tmp;
      st = ST_OK;
      case (op)
        OP_INSERT: begin
          if (held >= LIST_DEPTH) begin
            st = ST_FULL;
          end else if (pos < 1 || pos > held + 1) begin
            st = ST_RANGE;
          end else begin
            for (int i = int'(held); i > int'(pos) - 1; i--) cells[i] = cells[i-1];
            cells[pos-1] = val;
            held++;
          end
          push_result(st, '0, 1'b1);
        end
        OP_DELETE: begin
          if (held == 0) begin
            st = ST_EMPTY;
          end else if (pos < 1 || pos > held) begin
            st = ST_RANGE;
          end else begin
            for (int i = int'(pos) - 1; i + 1 < int'(held); i++) cells[i] = cells[i+1];
            held--;
          end
          push_result(st, '0, 1'b1);
        end
        OP_REVERSE: begin
          for (int k = 0; k < int'(held) / 2; k++) begin
            tmp = cells[k];
            cells[k] = cells[int'(held) - 1 - k];
            cells[int'(held) - 1 - k] = tmp;
          end
          push_result(ST_OK, '0, 1'b1);
        end
        default: begin
          if (held == 0) begin
            push_result(ST_EMPTY, '0, 1'b1);
          end else begin
            for (int k = 0; k < int'(held); k++) push_result(ST_OK, cells[k], k == int'(held) - 1);
          end
        end
      endcase
    endfunction

    function void check_result(logic [1:0] st, logic signed [VAL_W-1:0] elem,
                               logic [LEN_W-1:0] len, logic fin);
      list_result_t exp_r;
      if (pending_results.size() == 0) begin
        faults++;
        $display("%0t: result with nothing expected: status %0d element %0d length %0d last %0d",
                 $time, st, elem, len, fin);
        return;
      end
      exp_r = pending_results.pop_front();
      if (st !== exp_r.status) begin
        faults++;
        $display("%0t: status expected %0d actual %0d", $time, exp_r.status, st);
      end
      if (elem !== exp_r.element) begin
        faults++;
        $display("%0t: element expected %0d actual %0d", $time, exp_r.element, elem);
      end
      if (len !== exp_r.length) begin
        faults++;
        $display("%0t: length expected %0d actual %0d", $time, exp_r.length, len);
      end
      if (fin !== exp_r.last) begin
        faults++;
        $display("%0t: last expected %0d actual %0d", $time, exp_r.last, fin);
      end
    endfunction
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic [1:0]              op_i;
  logic [POS_W-1:0]        position_i;
  logic signed [VAL_W-1:0] value_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic [1:0]              status_o;
  logic signed [VAL_W-1:0] element_o;
  logic [LEN_W-1:0]        length_o;
  logic                    last_o;

  bit         calm;
  bit         long_hold_req;
  list_shadow shadow = new();

  positional_list_engine uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .position_i  (position_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .element_o   (element_o),
    .length_o    (length_o),
    .last_o      (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("positional_list_engine: mismatch");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      shadow.check_result(status_o, element_o, length_o, last_o);
    end
  end

  // The result side stalls in random bursts and, once, for a long stretch.
  initial begin
    out_ready_i <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  end

  task automatic send_request(input op_e op, input logic [POS_W-1:0] pos,
                              input logic signed [VAL_W-1:0] val);
    in_valid_i <= 1'b1;
    op_i       <= op;
    position_i <= pos;
    value_i    <= val;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    shadow.apply_request(op, pos, val);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
  endtask

  task automatic send_random(input bit growing);
    int unsigned      len;
    int unsigned      pick;
    int unsigned      bound;
    op_e              op;
    logic [POS_W-1:0] pos;
    len  = shadow.held_count();
    pick = $urandom_range(0, 99);
    if (pick < 55) op = growing ? OP_INSERT : OP_DELETE;
    else if (pick < 70) op = growing ? OP_DELETE : OP_INSERT;
    else if (pick < 85) op = OP_REVERSE;
    else op = OP_DUMP;
    if (op == OP_REVERSE || op == OP_DUMP) begin
      pos = POS_W'($urandom_range(0, 31));
    end else if ($urandom_range(0, 9) == 0) begin
      bound = (op == OP_INSERT) ? len + 2 : len + 1;
      if (bound > 31 || $urandom_range(0, 3) == 0) pos = '0;
      else pos = POS_W'($urandom_range(bound, 31));
    end else if (op == OP_INSERT) begin
      pos = POS_W'($urandom_range(1, len + 1));
    end else begin
      pos = (len == 0) ? POS_W'($urandom_range(1, 31)) : POS_W'($urandom_range(1, len));
    end
    send_request(op, pos, $urandom());
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i <= 1'b0;
    op_i       <= OP_INSERT;
    position_i <= '0;
    value_i    <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    send_request(OP_DUMP, 5'd1, 32'sd0);
    send_request(OP_DELETE, 5'd1, 32'sd0);
    send_request(OP_DELETE, 5'd0, 32'sd0);
    send_request(OP_REVERSE, 5'd0, 32'sd0);
    send_request(OP_INSERT, 5'd0, 32'sd5);
    send_request(OP_INSERT, 5'd2, 32'sd5);
    send_request(OP_INSERT, 5'd1, 32'sh8000_0000);
    send_request(OP_REVERSE, 5'd31, 32'sd0);
    send_request(OP_DUMP, 5'd0, 32'sd0);
    send_request(OP_INSERT, 5'd2, 32'sh7fff_ffff);
    send_request(OP_INSERT, 5'd1, -32'sd1);
    send_request(OP_INSERT, 5'd2, 32'sd0);
    send_request(OP_INSERT, 5'd31, 32'sd9);
    send_request(OP_INSERT, 5'd16, 32'sh5555_5555);
    send_request(OP_DELETE, 5'd0, 32'sd0);
    send_request(OP_DELETE, 5'd5, 32'sd0);
    send_request(OP_DUMP, 5'd0, 32'sd0);
    send_request(OP_REVERSE, 5'd0, 32'sd0);
    send_request(OP_DUMP, 5'd0, 32'sd0);
    send_request(OP_DELETE, 5'd4, 32'sd0);
    send_request(OP_DELETE, 5'd1, 32'sd0);
    send_request(OP_DUMP, 5'd0, 32'sd0);

    // Alternate between filling the list and draining it.
    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 2) long_hold_req = 1'b1;
      if (phase == 5) calm = 1'b1;
      for (int n = 0; n < int'(PHASE_ITEMS); n++) send_random(phase % 2 == 0);
    end
    in_valid_i <= 1'b0;

    while (shadow.waiting() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (shadow.faults == 0 && shadow.waiting() == 0) begin
      $display("positional_list_engine: match");
    end else begin
      $display("positional_list_engine: mismatch");
    end
    $finish;
  end

endmodule
